// ===== hdl/tccw_pkg.sv =====
// Shared constants, codes and word types of the text console cell writer.
package tccw_pkg;

   // Screen geometry and tab spacing
   localparam int COLUMNS  = 80;
   localparam int ROWS     = 25;
   localparam int TAB_STOP = 8;
   localparam int CELLS    = ROWS * COLUMNS;

   // Field widths of the words on the ports
   localparam int CELL_W = 11;
   localparam int CHAR_W = 8;
   localparam int ATTR_W = 8;

   // Internal widths that follow from the geometry
   localparam int CELL_AW   = $clog2(CELLS);
   localparam int ROW_W     = $clog2(ROWS);
   localparam int COL_W     = $clog2(COLUMNS);
   localparam int PHASE_W   = $clog2(TAB_STOP);
   localparam int TAB_CNT_W = $clog2(TAB_STOP + 1);

   // Character codes with special handling, and the blank cell
   localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'd8;
   localparam logic [CHAR_W-1:0] CHAR_TAB       = 8'd9;
   localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'd10;
   localparam logic [CHAR_W-1:0] CHAR_BLANK     = 8'd32;
   localparam logic [ATTR_W-1:0] RESET_ATTR     = 8'd7;

   // Operation kinds decided by the front
   localparam int OP_KIND_W = 3;
   localparam logic [OP_KIND_W-1:0] OP_READ      = 3'd0;
   localparam logic [OP_KIND_W-1:0] OP_PLAIN     = 3'd1;
   localparam logic [OP_KIND_W-1:0] OP_NEWLINE   = 3'd2;
   localparam logic [OP_KIND_W-1:0] OP_TAB       = 3'd3;
   localparam logic [OP_KIND_W-1:0] OP_BACKSPACE = 3'd4;

   // Queue depths
   localparam int OPQ_DEPTH  = 2;
   localparam int RSPQ_DEPTH = 2;

   // Command words
   localparam logic CMD_PUT  = 1'b0;
   localparam logic CMD_READ = 1'b1;

   typedef struct packed {
      logic              command;
      logic [CHAR_W-1:0] char_code;
      logic [CELL_W-1:0] cell_index;
   } req_type;

   typedef struct packed {
      logic [CELL_W-1:0] cursor_cell;
      logic [CHAR_W-1:0] read_char;
      logic [ATTR_W-1:0] read_attr;
   } rsp_type;

   typedef struct packed {
      logic [OP_KIND_W-1:0] kind;
      logic [CHAR_W-1:0]    char_code;
      logic [CELL_W-1:0]    cell_index;
   } op_type;

   typedef struct packed {
      logic   valid;
      op_type op;
   } opq_type;

   typedef struct packed {
      logic clearing;
   } back_status_type;

endpackage

// ===== hdl/tccw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tccw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2000,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry, read one entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/tccw_front.sv =====
// Input side: accept request words, classify them and queue them for the back.
module tccw_front import tccw_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_push,
   output logic            req_full,
   input  req_type         req_word,
   input  back_status_type status,
   input  logic            op_pop,
   output opq_type         opq
);

   localparam int PTR_W = $clog2(OPQ_DEPTH);
   localparam int CNT_W = $clog2(OPQ_DEPTH + 1);

   op_type           entry_ff [OPQ_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             accept;
   logic             take;
   op_type           op_new;

   // Classify the incoming word
   always_comb begin
      op_new.char_code  = req_word.char_code;
      op_new.cell_index = req_word.cell_index;
      if (req_word.command == CMD_READ) begin
         op_new.kind = OP_READ;
      end else begin
         case (req_word.char_code)
            CHAR_NEWLINE:   op_new.kind = OP_NEWLINE;
            CHAR_TAB:       op_new.kind = OP_TAB;
            CHAR_BACKSPACE: op_new.kind = OP_BACKSPACE;
            default:        op_new.kind = OP_PLAIN;
         endcase
      end
   end

   // Hold off words while the queue is full or the screen is being cleared
   assign req_full = (count_ff == CNT_W'(OPQ_DEPTH)) || status.clearing;
   assign accept   = req_push && !req_full;
   assign take     = op_pop && (count_ff != '0);

   assign opq.valid = (count_ff != '0);
   assign opq.op    = entry_ff[rd_ptr_ff];

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (accept) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(OPQ_DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_ff + 1'b1);
      end
      if (take) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(OPQ_DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_ff + 1'b1);
      end
      if (accept && !take) begin
         count_in = CNT_W'(count_ff + 1'b1);
      end else if (take && !accept) begin
         count_in = CNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the classified word
   always_ff @(posedge clock) begin
      if (accept) begin
         entry_ff[wr_ptr_ff] <= op_new;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(OPQ_DEPTH))
      else $error("operation queue count above depth");

   a_count_grows: assert property (@(posedge clock) disable iff (reset)
      (accept && !take) |=> (count_ff == CNT_W'($past(count_ff) + 1'b1)))
      else $error("operation queue lost an accepted word");

endmodule

// ===== hdl/tccw_back.sv =====
// Back side: cursor, attribute register and the sequencer that edits the screen store.
module tccw_back import tccw_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_enable,
   input  logic [ATTR_W-1:0] csr_write_data,
   input  opq_type           opq,
   output logic              op_pop,
   output back_status_type   status,
   output logic              rsp_push,
   output rsp_type           rsp_word,
   input  logic              rsp_full
);

   localparam int ST_W = 3;
   localparam logic [ST_W-1:0] S_CLEAR     = 3'd0;
   localparam logic [ST_W-1:0] S_IDLE      = 3'd1;
   localparam logic [ST_W-1:0] S_READ      = 3'd2;
   localparam logic [ST_W-1:0] S_ATTR      = 3'd3;
   localparam logic [ST_W-1:0] S_TAB       = 3'd4;
   localparam logic [ST_W-1:0] S_BS_ATTR   = 3'd5;
   localparam logic [ST_W-1:0] S_SCR_COPY  = 3'd6;
   localparam logic [ST_W-1:0] S_SCR_BLANK = 3'd7;

   localparam logic [PHASE_W-1:0] LAST_PHASE = PHASE_W'((COLUMNS - 1) % TAB_STOP);

   logic [ST_W-1:0]      state_ff, state_in;
   logic [ST_W-1:0]      ret_ff, ret_in;
   logic [CELL_AW-1:0]   cur_ff, cur_in;
   logic [ROW_W-1:0]     row_ff, row_in;
   logic [COL_W-1:0]     col_ff, col_in;
   logic [PHASE_W-1:0]   phase_ff, phase_in;
   logic [TAB_CNT_W-1:0] cnt_ff, cnt_in;
   logic [CELL_AW-1:0]   sc_ff, sc_in;
   logic                 copy_vld_ff, copy_vld_in;
   logic [CELL_AW-1:0]   copy_addr_ff, copy_addr_in;
   logic                 oor_ff, oor_in;
   logic [ATTR_W-1:0]    attr_ff;

   // Memory port signals
   logic               wr_char_en;
   logic               wr_attr_en;
   logic [CELL_AW-1:0] wr_addr;
   logic [CHAR_W-1:0]  wr_char;
   logic [ATTR_W-1:0]  wr_attr;
   logic [CELL_AW-1:0] rd_addr;
   logic [CHAR_W-1:0]  rd_char;
   logic [ATTR_W-1:0]  rd_attr;

   // Cursor step forward
   logic               last_col;
   logic               last_row;
   logic               adv_wrap;
   logic [CELL_AW-1:0] adv_cur;
   logic [ROW_W-1:0]   adv_row;
   logic [COL_W-1:0]   adv_col;
   logic [PHASE_W-1:0] adv_phase;

   // Cursor step back
   logic               at_origin;
   logic [CELL_AW-1:0] bs_cur;
   logic [ROW_W-1:0]   bs_row;
   logic [COL_W-1:0]   bs_col;
   logic [PHASE_W-1:0] bs_phase;

   logic               start_scroll;
   logic [ST_W-1:0]    scroll_ret;
   logic [ST_W-1:0]    tab_next;

   tccw_ram #(.WIDTH(CHAR_W), .DEPTH(CELLS)) u_char_ram (
      .clock   (clock),
      .wr_en   (wr_char_en),
      .wr_addr (wr_addr),
      .wr_data (wr_char),
      .rd_addr (rd_addr),
      .rd_data (rd_char)
   );

   tccw_ram #(.WIDTH(ATTR_W), .DEPTH(CELLS)) u_attr_ram (
      .clock   (clock),
      .wr_en   (wr_attr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_attr),
      .rd_addr (rd_addr),
      .rd_data (rd_attr)
   );

   assign status.clearing = (state_ff == S_CLEAR);

   // Advance the cursor by one cell
   always_comb begin
      last_col = (col_ff == COL_W'(COLUMNS - 1));
      last_row = (row_ff == ROW_W'(ROWS - 1));
      adv_wrap = last_col && last_row;
      adv_cur  = CELL_AW'(cur_ff + 1'b1);
      if (last_col) begin
         adv_row   = ROW_W'(row_ff + 1'b1);
         adv_col   = '0;
         adv_phase = '0;
      end else begin
         adv_row   = row_ff;
         adv_col   = COL_W'(col_ff + 1'b1);
         adv_phase = (phase_ff == PHASE_W'(TAB_STOP - 1)) ? '0 : PHASE_W'(phase_ff + 1'b1);
      end
   end

   // Step the cursor back one cell, stopping at the first cell
   always_comb begin
      at_origin = (cur_ff == '0);
      bs_cur    = cur_ff;
      bs_row    = row_ff;
      bs_col    = col_ff;
      bs_phase  = phase_ff;
      if (!at_origin) begin
         bs_cur = CELL_AW'(cur_ff - 1'b1);
         if (col_ff == '0) begin
            bs_row   = ROW_W'(row_ff - 1'b1);
            bs_col   = COL_W'(COLUMNS - 1);
            bs_phase = LAST_PHASE;
         end else begin
            bs_col   = COL_W'(col_ff - 1'b1);
            bs_phase = (phase_ff == '0) ? PHASE_W'(TAB_STOP - 1) : PHASE_W'(phase_ff - 1'b1);
         end
      end
   end

   assign tab_next = (cnt_ff == TAB_CNT_W'(1)) ? S_ATTR : S_TAB;

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      cur_in       = cur_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      phase_in     = phase_ff;
      cnt_in       = cnt_ff;
      sc_in        = sc_ff;
      copy_vld_in  = 1'b0;
      copy_addr_in = copy_addr_ff;
      oor_in       = oor_ff;
      op_pop       = 1'b0;
      rsp_push     = 1'b0;
      wr_char_en   = 1'b0;
      wr_attr_en   = 1'b0;
      wr_addr      = '0;
      wr_char      = '0;
      wr_attr      = '0;
      rd_addr      = '0;
      start_scroll = 1'b0;
      scroll_ret   = S_ATTR;

      rsp_word.cursor_cell = CELL_W'(cur_ff);
      rsp_word.read_char   = '0;
      rsp_word.read_attr   = '0;

      // Finish a scroll copy in the cycle after its read
      if (copy_vld_ff) begin
         wr_char_en = 1'b1;
         wr_attr_en = 1'b1;
         wr_addr    = copy_addr_ff;
         wr_char    = rd_char;
         wr_attr    = rd_attr;
      end

      case (state_ff)
         S_CLEAR: begin
            wr_char_en = 1'b1;
            wr_attr_en = 1'b1;
            wr_addr    = sc_ff;
            wr_char    = CHAR_BLANK;
            wr_attr    = RESET_ATTR;
            if (sc_ff == CELL_AW'(CELLS - 1)) begin
               sc_in    = '0;
               state_in = S_IDLE;
            end else begin
               sc_in = CELL_AW'(sc_ff + 1'b1);
            end
         end
         S_IDLE: begin
            if (opq.valid && !rsp_full) begin
               op_pop = 1'b1;
               case (opq.op.kind)
                  OP_READ: begin
                     oor_in   = !(32'(opq.op.cell_index) < 32'(CELLS));
                     rd_addr  = oor_in ? '0 : CELL_AW'(opq.op.cell_index);
                     state_in = S_READ;
                  end
                  OP_PLAIN: begin
                     wr_char_en = 1'b1;
                     wr_attr_en = 1'b1;
                     wr_addr    = cur_ff;
                     wr_char    = opq.op.char_code;
                     wr_attr    = attr_ff;
                     cur_in     = adv_cur;
                     row_in     = adv_row;
                     col_in     = adv_col;
                     phase_in   = adv_phase;
                     state_in   = S_ATTR;
                     start_scroll = adv_wrap;
                  end
                  OP_NEWLINE: begin
                     if (last_row) begin
                        start_scroll = 1'b1;
                     end else begin
                        cur_in   = CELL_AW'(cur_ff - CELL_AW'(col_ff) + CELL_AW'(COLUMNS));
                        row_in   = ROW_W'(row_ff + 1'b1);
                        col_in   = '0;
                        phase_in = '0;
                        state_in = S_ATTR;
                     end
                  end
                  OP_TAB: begin
                     cnt_in   = TAB_CNT_W'(TAB_STOP) - TAB_CNT_W'(phase_ff);
                     state_in = S_TAB;
                  end
                  OP_BACKSPACE: begin
                     wr_char_en = 1'b1;
                     wr_attr_en = 1'b1;
                     wr_addr    = bs_cur;
                     wr_char    = CHAR_BLANK;
                     wr_attr    = attr_ff;
                     cur_in     = bs_cur;
                     row_in     = bs_row;
                     col_in     = bs_col;
                     phase_in   = bs_phase;
                     state_in   = S_BS_ATTR;
                  end
                  default: begin
                     state_in = S_ATTR;
                  end
               endcase
            end
         end
         S_READ: begin
            rsp_push = 1'b1;
            if (!oor_ff) begin
               rsp_word.read_char = rd_char;
               rsp_word.read_attr = rd_attr;
            end
            state_in = S_IDLE;
         end
         S_ATTR: begin
            // Set the attribute of the cursor cell, keep its character
            wr_attr_en = 1'b1;
            wr_addr    = cur_ff;
            wr_attr    = attr_ff;
            rsp_push   = 1'b1;
            state_in   = S_IDLE;
         end
         S_TAB: begin
            wr_char_en   = 1'b1;
            wr_attr_en   = 1'b1;
            wr_addr      = cur_ff;
            wr_char      = CHAR_BLANK;
            wr_attr      = attr_ff;
            cur_in       = adv_cur;
            row_in       = adv_row;
            col_in       = adv_col;
            phase_in     = adv_phase;
            cnt_in       = TAB_CNT_W'(cnt_ff - 1'b1);
            state_in     = tab_next;
            start_scroll = adv_wrap;
            scroll_ret   = tab_next;
         end
         S_BS_ATTR: begin
            // Set the attribute of the cell after the blanked one
            wr_attr_en = 1'b1;
            wr_addr    = CELL_AW'(cur_ff + 1'b1);
            wr_attr    = attr_ff;
            rsp_push   = 1'b1;
            state_in   = S_IDLE;
         end
         S_SCR_COPY: begin
            // Read one row down, write back next cycle
            rd_addr      = CELL_AW'(sc_ff + CELL_AW'(COLUMNS));
            copy_vld_in  = 1'b1;
            copy_addr_in = sc_ff;
            if (sc_ff == CELL_AW'(CELLS - COLUMNS - 1)) begin
               sc_in    = CELL_AW'(CELLS - COLUMNS);
               state_in = S_SCR_BLANK;
            end else begin
               sc_in = CELL_AW'(sc_ff + 1'b1);
            end
         end
         S_SCR_BLANK: begin
            // Wait for the last copy write, then blank the bottom row
            if (!copy_vld_ff) begin
               wr_char_en = 1'b1;
               wr_attr_en = 1'b1;
               wr_addr    = sc_ff;
               wr_char    = CHAR_BLANK;
               wr_attr    = attr_ff;
               if (sc_ff == CELL_AW'(CELLS - 1)) begin
                  sc_in    = '0;
                  state_in = ret_ff;
               end else begin
                  sc_in = CELL_AW'(sc_ff + 1'b1);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Enter the scroll: cursor to the bottom-left cell
      if (start_scroll) begin
         sc_in    = '0;
         cur_in   = CELL_AW'(CELLS - COLUMNS);
         row_in   = ROW_W'(ROWS - 1);
         col_in   = '0;
         phase_in = '0;
         ret_in   = scroll_ret;
         state_in = S_SCR_COPY;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_CLEAR;
         ret_ff      <= S_IDLE;
         cur_ff      <= '0;
         row_ff      <= '0;
         col_ff      <= '0;
         phase_ff    <= '0;
         cnt_ff      <= '0;
         sc_ff       <= '0;
         copy_vld_ff <= 1'b0;
         oor_ff      <= 1'b0;
         attr_ff     <= RESET_ATTR;
      end else begin
         state_ff    <= state_in;
         ret_ff      <= ret_in;
         cur_ff      <= cur_in;
         row_ff      <= row_in;
         col_ff      <= col_in;
         phase_ff    <= phase_in;
         cnt_ff      <= cnt_in;
         sc_ff       <= sc_in;
         copy_vld_ff <= copy_vld_in;
         oor_ff      <= oor_in;
         if (csr_write_enable) begin
            attr_ff <= csr_write_data;
         end
      end
   end

   // Copy write address
   always_ff @(posedge clock) begin
      copy_addr_ff <= copy_addr_in;
   end

   a_cursor_map: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |->
         (32'(cur_ff) == 32'(row_ff) * COLUMNS + 32'(col_ff)))
      else $error("cursor index out of step with row and column");

   a_copy_in_scroll: assert property (@(posedge clock) disable iff (reset)
      copy_vld_ff |-> ((state_ff == S_SCR_COPY) || (state_ff == S_SCR_BLANK)))
      else $error("scroll copy write outside a scroll");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> !rsp_full)
      else $error("result pushed into a full queue");

endmodule

// ===== hdl/tccw_rsp_queue.sv =====
// Result queue between the back and the result port.
module tccw_rsp_queue import tccw_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_word,
   output logic    full,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_word
);

   localparam int PTR_W = $clog2(RSPQ_DEPTH);
   localparam int CNT_W = $clog2(RSPQ_DEPTH + 1);

   rsp_type          entry_ff [RSPQ_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             put;
   logic             take;

   assign full      = (count_ff == CNT_W'(RSPQ_DEPTH));
   assign rsp_empty = (count_ff == '0);
   assign put       = push && !full;
   assign take      = rsp_pop && !rsp_empty;
   assign rsp_word  = entry_ff[rd_ptr_ff];

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (put) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(RSPQ_DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_ff + 1'b1);
      end
      if (take) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(RSPQ_DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_ff + 1'b1);
      end
      if (put && !take) begin
         count_in = CNT_W'(count_ff + 1'b1);
      end else if (take && !put) begin
         count_in = CNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the result word
   always_ff @(posedge clock) begin
      if (put) begin
         entry_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

// ===== hdl/text_console_cell_writer.sv =====
// An accepted plain character or read is stored in the operation queue, taken by the back
// in S_IDLE and pushed from S_ATTR or S_READ into the result queue; S_IDLE waits while that
// queue is full. The back works one operation at a time, a tab writing one space per step
// in S_TAB. A scroll copies the rows up one cell per cycle through the screen RAM ports.
// Reset: cursor 0, attribute 7; after reset all CELLS (2000) cells are swept to blanks and
// full stays high until the sweep ends.
module text_console_cell_writer import tccw_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  req_type           req_word,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output rsp_type           rsp_word,
   input  logic              csr_write_enable,
   input  logic [ATTR_W-1:0] csr_write_data
);

   opq_type         opq;
   logic            op_pop;
   back_status_type status;
   logic            rsp_push;
   rsp_type         back_word;
   logic            rsp_full;

   tccw_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_word (req_word),
      .status   (status),
      .op_pop   (op_pop),
      .opq      (opq)
   );

   tccw_back u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .opq              (opq),
      .op_pop           (op_pop),
      .status           (status),
      .rsp_push         (rsp_push),
      .rsp_word         (back_word),
      .rsp_full         (rsp_full)
   );

   tccw_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_word (back_word),
      .full      (rsp_full),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_word  (rsp_word)
   );

endmodule
